>>> hdl/fcts_pkg.sv
// fcts_pkg: shared types and codes of the floppy CHS transfer sequencer.
// Used by the divider, the core and the checker; depends on nothing.

package fcts_pkg;

	localparam logic [1:0] OP_REQUEST = 2'd0;
	localparam logic [1:0] OP_FETCH   = 2'd1;
	localparam logic [1:0] OP_RESULT  = 2'd2;

	localparam logic [2:0] STAT_ACCEPTED  = 3'd0;
	localparam logic [2:0] STAT_BAD_REQ   = 3'd1;
	localparam logic [2:0] STAT_ISSUED    = 3'd2;
	localparam logic [2:0] STAT_NO_CHUNK  = 3'd3;
	localparam logic [2:0] STAT_XFER_OK   = 3'd4;
	localparam logic [2:0] STAT_WRITE_PROT = 3'd5;
	localparam logic [2:0] STAT_XFER_FAIL = 3'd6;

	localparam logic [1:0] CFG_SECTORS_PER_TRACK = 2'd0;
	localparam logic [1:0] CFG_FS_BLOCK_SECTORS  = 2'd1;
	localparam logic [1:0] CFG_TOTAL_SECTORS     = 2'd2;

	localparam logic [5:0]  RST_SECTORS_PER_TRACK = 6'd18;
	localparam logic [3:0]  RST_FS_BLOCK_SECTORS  = 4'd2;
	localparam logic [14:0] RST_TOTAL_SECTORS     = 15'd2880;

	localparam logic [7:0] ST0_TEST_MASK    = 8'hf8;
	localparam int unsigned ST1_NOT_WRITABLE_BIT = 1;

	localparam int unsigned LBA_W = 15;
	localparam int unsigned SPC_W = 7;

	typedef struct packed {
		logic [2:0] status;
		logic       drive;
		logic [7:0] cylinder;
		logic       head;
		logic [5:0] sector;
		logic [6:0] count;
		logic       write_dir;
	} result_t;

	function automatic result_t no_chunk(input logic [2:0] status);
		result_t r;
		r = '0;
		r.status = status;
		return r;
	endfunction

endpackage

>>> hdl/fcts_divu.sv
// fcts_divu: bit-serial restoring divider, one quotient bit per cycle.
// Divides a sector address by the cylinder size; depends on fcts_pkg.

module fcts_divu (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [fcts_pkg::LBA_W-1:0]     dividend,
	input  logic [fcts_pkg::SPC_W-1:0]     divisor,
	output logic                           done,
	output logic [fcts_pkg::LBA_W-1:0]     quotient,
	output logic [fcts_pkg::SPC_W-1:0]     remainder
);

	localparam int unsigned CNT_W = $clog2(fcts_pkg::LBA_W);

	logic                         run_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [fcts_pkg::LBA_W-1:0]   quo_q;
	logic [fcts_pkg::SPC_W-1:0]   rem_q;
	logic [fcts_pkg::SPC_W:0]     shifted;
	logic                         fits;
	logic [fcts_pkg::SPC_W:0]     diff;

	assign shifted = {rem_q, quo_q[fcts_pkg::LBA_W-1]};
	assign fits    = shifted >= {1'b0, divisor};
	assign diff    = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CNT_W'(fcts_pkg::LBA_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[fcts_pkg::LBA_W-2:0], fits};
			rem_q <= fits ? diff[fcts_pkg::SPC_W-1:0] : shifted[fcts_pkg::SPC_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> hdl/floppy_chs_transfer_sequencer_core.sv
// floppy_chs_transfer_sequencer_core: splits block requests into cylinder-bounded
// CHS chunks and judges controller results. Depends on fcts_pkg and fcts_divu.
//
// Usage:
//  - Command channel: present op and its fields with start high; the command is
//    taken at a clock edge where start is high and busy is low. busy stays high
//    until the command's work is finished.
//  - Result channel: done pulses for one cycle with status and chunk fields.
//    The receiver cannot stall; each result is shown exactly once.
//  - A fetch of a new chunk waits for the serial divider splitting the cursor into
//    cylinder and offset; a repeated fetch returns the pending chunk without it.
//    A result with clean status bytes is judged via the product registers.
//    An unused op keeps busy high for one cycle and returns nothing.
//  - A new command can be taken the cycle after busy falls, while done of the
//    previous command is still showing.
//  - Config: cfg_we writes cfg_data into register cfg_index at once; write only
//    while idle. Reset restores default geometry (18 sectors, 2 per block,
//    2880 total) and closes any request.

module floppy_chs_transfer_sequencer_core #(
	parameter int MAX_CYLINDERS         = 255,
	parameter int MAX_SECTORS_PER_TRACK = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic        is_write,
	input  logic        drive,
	input  logic [14:0] block,
	input  logic [14:0] block_count,
	input  logic [7:0]  st0,
	input  logic [7:0]  st1,
	input  logic [7:0]  st2,
	input  logic [7:0]  res_cylinder,
	input  logic [7:0]  res_head,
	input  logic [7:0]  res_sector,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	output logic        done,
	output logic [2:0]  status,
	output logic        out_drive,
	output logic [7:0]  cylinder,
	output logic        head,
	output logic [5:0]  sector,
	output logic [6:0]  count,
	output logic        write_dir
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_REQ   = 3'd1;
	localparam logic [2:0] S_FETCH = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_RES   = 3'd4;
	localparam logic [2:0] S_MUL   = 3'd5;
	localparam logic [2:0] S_SUM   = 3'd6;

	logic [2:0]  state_q;

	logic [5:0]  spt_cfg_q;
	logic [3:0]  fbs_cfg_q;
	logic [14:0] total_cfg_q;

	logic [14:0] cursor_q;
	logic [14:0] remaining_q;
	logic        active_q;
	logic        pending_q;
	logic        req_write_q;
	logic        req_drive_q;
	logic [7:0]  chunk_cyl_q;
	logic        chunk_head_q;
	logic [5:0]  chunk_sector_q;
	logic [6:0]  chunk_count_q;

	logic [1:0]  op_q;
	logic        is_write_q;
	logic        drive_q;
	logic [14:0] block_q;
	logic [14:0] block_count_q;
	logic [7:0]  st0_q;
	logic [7:0]  st1_q;
	logic [7:0]  st2_q;
	logic [7:0]  rc_q;
	logic [7:0]  rh_q;
	logic [7:0]  rs_q;

	logic signed [16:0] p_cyl_q;
	logic signed [15:0] p_head_q;
	logic signed [8:0]  d_sec_q;

	logic                  done_q;
	fcts_pkg::result_t     res_q;
	fcts_pkg::result_t     chunk_res;
	fcts_pkg::result_t     fresh_res;

	logic [5:0]  spt;
	logic [6:0]  spc;
	logic [18:0] req_start;
	logic [18:0] req_n;
	logic [19:0] req_end;
	logic        req_bad;

	logic        div_start;
	logic        div_done;
	logic [14:0] div_quo;
	logic [6:0]  div_rem;
	logic        place_head;
	logic [5:0]  place_sector;
	logic [6:0]  room;
	logic [6:0]  place_count;

	logic signed [8:0]  d_cyl;
	logic signed [8:0]  d_head;
	logic signed [8:0]  d_sec;
	logic signed [7:0]  spc_s;
	logic signed [6:0]  spt_s;
	logic signed [16:0] p_cyl;
	logic signed [15:0] p_head;
	logic signed [17:0] sec_dist;
	logic               st_fail;
	logic [14:0]        rem_after;

	// effective track size
	always_comb begin
		spt = spt_cfg_q;
		if (spt == 6'd0)
			spt = 6'd1;
		if (spt > 6'(MAX_SECTORS_PER_TRACK))
			spt = 6'(MAX_SECTORS_PER_TRACK);
	end
	assign spc = {spt, 1'b0};

	assign req_start = {4'b0, block_q} * {15'b0, fbs_cfg_q};
	assign req_n     = {4'b0, block_count_q} * {15'b0, fbs_cfg_q};
	assign req_end   = {1'b0, req_start} + {1'b0, req_n};
	assign req_bad   = (req_start >= {4'b0, total_cfg_q}) || (req_n == 19'd0) ||
	                   (req_n > {4'b0, total_cfg_q}) || (req_end > {5'b0, total_cfg_q});

	assign div_start = (state_q == S_FETCH) && active_q && !pending_q;

	fcts_divu u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (cursor_q),
		.divisor   (spc),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign place_head   = div_rem >= {1'b0, spt};
	assign place_sector = (place_head ? (div_rem[5:0] - spt) : div_rem[5:0]) + 6'd1;
	assign room         = spc - div_rem;
	assign place_count  = (remaining_q < {8'b0, room}) ? remaining_q[6:0] : room;

	assign d_cyl  = $signed({1'b0, rc_q}) - $signed({1'b0, chunk_cyl_q});
	assign d_head = $signed({1'b0, rh_q}) - $signed({8'b0, chunk_head_q});
	assign d_sec  = $signed({1'b0, rs_q}) - $signed({3'b0, chunk_sector_q});
	assign spc_s  = $signed({1'b0, spc});
	assign spt_s  = $signed({1'b0, spt});
	assign p_cyl  = d_cyl * spc_s;
	assign p_head = d_head * spt_s;
	assign sec_dist = 18'(p_cyl_q) + 18'(p_head_q) + 18'(d_sec_q);

	assign st_fail   = ((st0_q & fcts_pkg::ST0_TEST_MASK) != 8'd0) || (st1_q != 8'd0) ||
	                   (st2_q != 8'd0);
	assign rem_after = ({8'b0, chunk_count_q} >= remaining_q) ? 15'd0 :
	                   remaining_q - {8'b0, chunk_count_q};

	always_comb begin
		chunk_res           = '0;
		chunk_res.status    = fcts_pkg::STAT_ISSUED;
		chunk_res.drive     = req_drive_q;
		chunk_res.cylinder  = chunk_cyl_q;
		chunk_res.head      = chunk_head_q;
		chunk_res.sector    = chunk_sector_q;
		chunk_res.count     = chunk_count_q;
		chunk_res.write_dir = req_write_q;
	end

	// newly placed chunk
	always_comb begin
		fresh_res          = chunk_res;
		fresh_res.cylinder = div_quo[7:0];
		fresh_res.head     = place_head;
		fresh_res.sector   = place_sector;
		fresh_res.count    = place_count;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_cfg_q   <= fcts_pkg::RST_SECTORS_PER_TRACK;
			fbs_cfg_q   <= fcts_pkg::RST_FS_BLOCK_SECTORS;
			total_cfg_q <= fcts_pkg::RST_TOTAL_SECTORS;
		end else if (cfg_we) begin
			case (cfg_index)
				fcts_pkg::CFG_SECTORS_PER_TRACK: spt_cfg_q   <= cfg_data[5:0];
				fcts_pkg::CFG_FS_BLOCK_SECTORS:  fbs_cfg_q   <= cfg_data[3:0];
				fcts_pkg::CFG_TOTAL_SECTORS:     total_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// command capture and product registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q          <= op;
			is_write_q    <= is_write;
			drive_q       <= drive;
			block_q       <= block;
			block_count_q <= block_count;
			st0_q         <= st0;
			st1_q         <= st1;
			st2_q         <= st2;
			rc_q          <= res_cylinder;
			rh_q          <= res_head;
			rs_q          <= res_sector;
		end
		if (state_q == S_MUL) begin
			p_cyl_q  <= p_cyl;
			p_head_q <= p_head;
			d_sec_q  <= d_sec;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			done_q         <= 1'b0;
			res_q          <= '0;
			cursor_q       <= '0;
			remaining_q    <= '0;
			active_q       <= 1'b0;
			pending_q      <= 1'b0;
			req_write_q    <= 1'b0;
			req_drive_q    <= 1'b0;
			chunk_cyl_q    <= '0;
			chunk_head_q   <= 1'b0;
			chunk_sector_q <= '0;
			chunk_count_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (op)
							fcts_pkg::OP_REQUEST: state_q <= S_REQ;
							fcts_pkg::OP_FETCH:   state_q <= S_FETCH;
							fcts_pkg::OP_RESULT:  state_q <= S_RES;
							default:              state_q <= S_REQ;
						endcase
					end
				end
				S_REQ: begin
					state_q <= S_IDLE;
					if (op_q == fcts_pkg::OP_REQUEST) begin
						done_q    <= 1'b1;
						pending_q <= 1'b0;
						if (req_bad) begin
							active_q <= 1'b0;
							res_q    <= fcts_pkg::no_chunk(fcts_pkg::STAT_BAD_REQ);
						end else begin
							cursor_q    <= req_start[14:0];
							remaining_q <= req_n[14:0];
							active_q    <= 1'b1;
							req_write_q <= is_write_q;
							req_drive_q <= drive_q;
							res_q       <= fcts_pkg::no_chunk(fcts_pkg::STAT_ACCEPTED);
						end
					end
				end
				S_FETCH: begin
					if (!active_q) begin
						done_q  <= 1'b1;
						res_q   <= fcts_pkg::no_chunk(fcts_pkg::STAT_NO_CHUNK);
						state_q <= S_IDLE;
					end else if (pending_q) begin
						done_q  <= 1'b1;
						res_q   <= chunk_res;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (div_quo >= 15'(MAX_CYLINDERS)) begin
							active_q <= 1'b0;
							res_q    <= fcts_pkg::no_chunk(fcts_pkg::STAT_NO_CHUNK);
						end else begin
							chunk_cyl_q    <= div_quo[7:0];
							chunk_head_q   <= place_head;
							chunk_sector_q <= place_sector;
							chunk_count_q  <= place_count;
							pending_q      <= 1'b1;
							res_q          <= fresh_res;
						end
					end
				end
				S_RES: begin
					if (!pending_q) begin
						done_q  <= 1'b1;
						res_q   <= fcts_pkg::no_chunk(fcts_pkg::STAT_NO_CHUNK);
						state_q <= S_IDLE;
					end else if (req_write_q && st1_q[fcts_pkg::ST1_NOT_WRITABLE_BIT]) begin
						pending_q <= 1'b0;
						done_q    <= 1'b1;
						res_q     <= fcts_pkg::no_chunk(fcts_pkg::STAT_WRITE_PROT);
						state_q   <= S_IDLE;
					end else if (st_fail) begin
						pending_q <= 1'b0;
						done_q    <= 1'b1;
						res_q     <= fcts_pkg::no_chunk(fcts_pkg::STAT_XFER_FAIL);
						state_q   <= S_IDLE;
					end else begin
						pending_q <= 1'b0;
						state_q   <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (sec_dist == $signed({11'b0, chunk_count_q})) begin
						cursor_q    <= cursor_q + {8'b0, chunk_count_q};
						remaining_q <= rem_after;
						if (rem_after == 15'd0)
							active_q <= 1'b0;
						res_q <= fcts_pkg::no_chunk(fcts_pkg::STAT_XFER_OK);
					end else begin
						res_q <= fcts_pkg::no_chunk(fcts_pkg::STAT_XFER_FAIL);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy      = state_q != S_IDLE;
	assign done      = done_q;
	assign status    = res_q.status;
	assign out_drive = res_q.drive;
	assign cylinder  = res_q.cylinder;
	assign head      = res_q.head;
	assign sector    = res_q.sector;
	assign count     = res_q.count;
	assign write_dir = res_q.write_dir;

endmodule

>>> hdl/fcts_checker.sv
// fcts_checker: port-level assertions for the transfer sequencer core.
// Bound to floppy_chs_transfer_sequencer_core; depends on fcts_pkg.

module fcts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic        out_drive,
	input logic [7:0]  cylinder,
	input logic        head,
	input logic [5:0]  sector,
	input logic [6:0]  count,
	input logic        write_dir
);

	// accepted transaction always occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_no_chunk_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != fcts_pkg::STAT_ISSUED |->
			!out_drive && cylinder == 8'd0 && !head && sector == 6'd0 &&
			count == 7'd0 && !write_dir)
		else $error("chunk fields nonzero without issued chunk");

	a_chunk_sane: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == fcts_pkg::STAT_ISSUED |-> sector != 6'd0 && count != 7'd0)
		else $error("issued chunk with zero sector or count");

endmodule

bind floppy_chs_transfer_sequencer_core fcts_checker u_fcts_checker (.*);

>>> tb/floppy_chs_transfer_sequencer_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for floppy_chs_transfer_sequencer_core: directed and random command
// sequences under several disk geometries, results checked against an in-bench sequencer model.
// Depends on fcts_pkg and the core RTL.

module floppy_chs_transfer_sequencer_core_tb;

	localparam int MAX_CYL = 255;
	localparam int MAX_SPT = 63;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 800000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [1:0]  op;
		logic        is_write;
		logic        drive;
		logic [14:0] block;
		logic [14:0] block_count;
		logic [7:0]  st0;
		logic [7:0]  st1;
		logic [7:0]  st2;
		logic [7:0]  res_cylinder;
		logic [7:0]  res_head;
		logic [7:0]  res_sector;
	} cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  op = '0;
	logic        is_write = 1'b0;
	logic        drive = 1'b0;
	logic [14:0] block = '0;
	logic [14:0] block_count = '0;
	logic [7:0]  st0 = '0;
	logic [7:0]  st1 = '0;
	logic [7:0]  st2 = '0;
	logic [7:0]  res_cylinder = '0;
	logic [7:0]  res_head = '0;
	logic [7:0]  res_sector = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [14:0] cfg_data = '0;
	logic        busy;
	logic        done;
	logic [2:0]  status;
	logic        out_drive;
	logic [7:0]  cylinder;
	logic        head;
	logic [5:0]  sector;
	logic [6:0]  count;
	logic        write_dir;

	floppy_chs_transfer_sequencer_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.is_write(is_write), .drive(drive), .block(block), .block_count(block_count),
		.st0(st0), .st1(st1), .st2(st2), .res_cylinder(res_cylinder),
		.res_head(res_head), .res_sector(res_sector), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .status(status),
		.out_drive(out_drive), .cylinder(cylinder), .head(head), .sector(sector),
		.count(count), .write_dir(write_dir)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sequencer model state
	logic [5:0]  cfg_spt = fcts_pkg::RST_SECTORS_PER_TRACK;
	logic [3:0]  cfg_fsb = fcts_pkg::RST_FS_BLOCK_SECTORS;
	logic [14:0] cfg_total = fcts_pkg::RST_TOTAL_SECTORS;
	logic [14:0] cur_sector = '0;
	logic [14:0] left_sectors = '0;
	bit          req_open = 1'b0;
	bit          chunk_out = 1'b0;
	bit          dir_write = 1'b0;
	bit          drv = 1'b0;
	logic [7:0]  c_cyl = '0;
	bit          c_head = 1'b0;
	logic [5:0]  c_sec = '0;
	logic [6:0]  c_cnt = '0;

	cmd_t              cmd_q[$];
	fcts_pkg::result_t due_results[$];
	cmd_t              cur_cmd;
	fcts_pkg::result_t mon_want;

	int pushed_n = 0;
	int accepted_n = 0;
	int items_n = 0;
	int checked_n = 0;
	int errors = 0;
	int idle_left = 0;
	bit no_idle = 1'b0;
	int unsigned cycles = 0;
	int stat_seen[8];

	task automatic flag_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= 40)
			$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	function automatic int unsigned eff_spt();
		int unsigned s;
		s = cfg_spt;
		if (s == 0) s = 1;
		if (s > MAX_SPT) s = MAX_SPT;
		return s;
	endfunction

	function automatic fcts_pkg::result_t chunk_result();
		fcts_pkg::result_t r;
		r = '0;
		r.status = fcts_pkg::STAT_ISSUED;
		r.drive = drv;
		r.cylinder = c_cyl;
		r.head = c_head;
		r.sector = c_sec;
		r.count = c_cnt;
		r.write_dir = dir_write;
		return r;
	endfunction

	task automatic advance_sequencer(input cmd_t c);
		fcts_pkg::result_t r;
		int unsigned first_s, n_s, spt, spc, cyl, off, room, tmp;
		int sec_dist;
		bit emits;
		r = '0;
		emits = 1'b1;
		case (c.op)
			fcts_pkg::OP_REQUEST: begin
				first_s = c.block;
				first_s = first_s * cfg_fsb;
				n_s = c.block_count;
				n_s = n_s * cfg_fsb;
				chunk_out = 1'b0;
				if (first_s >= cfg_total || n_s == 0 || n_s > cfg_total ||
					first_s + n_s > cfg_total) begin
					req_open = 1'b0;
					r.status = fcts_pkg::STAT_BAD_REQ;
				end else begin
					cur_sector = first_s[14:0];
					left_sectors = n_s[14:0];
					req_open = 1'b1;
					dir_write = c.is_write;
					drv = c.drive;
					r.status = fcts_pkg::STAT_ACCEPTED;
				end
			end
			fcts_pkg::OP_FETCH: begin
				if (!req_open) begin
					r.status = fcts_pkg::STAT_NO_CHUNK;
				end else if (chunk_out) begin
					r = chunk_result();
				end else begin
					spt = eff_spt();
					spc = 2 * spt;
					cyl = cur_sector / spc;
					off = cur_sector % spc;
					if (cyl >= MAX_CYL) begin
						req_open = 1'b0;
						r.status = fcts_pkg::STAT_NO_CHUNK;
					end else begin
						room = spc - off;
						c_cyl = cyl[7:0];
						tmp = off / spt;
						c_head = tmp[0];
						tmp = off % spt + 1;
						c_sec = tmp[5:0];
						tmp = (left_sectors < room) ? left_sectors : room;
						c_cnt = tmp[6:0];
						chunk_out = 1'b1;
						r = chunk_result();
					end
				end
			end
			fcts_pkg::OP_RESULT: begin
				if (!chunk_out) begin
					r.status = fcts_pkg::STAT_NO_CHUNK;
				end else begin
					chunk_out = 1'b0;
					if (dir_write && c.st1[fcts_pkg::ST1_NOT_WRITABLE_BIT]) begin
						r.status = fcts_pkg::STAT_WRITE_PROT;
					end else if ((c.st0 & fcts_pkg::ST0_TEST_MASK) != 0 || c.st1 != 0 ||
						c.st2 != 0) begin
						r.status = fcts_pkg::STAT_XFER_FAIL;
					end else begin
						spt = eff_spt();
						sec_dist = (int'(c.res_cylinder) - int'(c_cyl)) * int'(2 * spt) +
							(int'(c.res_head) - int'(c_head)) * int'(spt) +
							(int'(c.res_sector) - int'(c_sec));
						if (sec_dist != int'(c_cnt)) begin
							r.status = fcts_pkg::STAT_XFER_FAIL;
						end else begin
							tmp = cur_sector + c_cnt;
							cur_sector = tmp[14:0];
							if (c_cnt >= left_sectors) begin
								left_sectors = '0;
							end else begin
								tmp = left_sectors - c_cnt;
								left_sectors = tmp[14:0];
							end
							if (left_sectors == 0) req_open = 1'b0;
							r.status = fcts_pkg::STAT_XFER_OK;
						end
					end
				end
			end
			default: emits = 1'b0;
		endcase
		if (emits) due_results.push_back(r);
	endtask

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_idle || roll < 50) return 0;
		if (roll < 75) return $urandom_range(1, 5);
		if (roll < 90) return $urandom_range(6, 25);
		return $urandom_range(26, 60);
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				advance_sequencer(cur_cmd);
				accepted_n++;
				if (accepted_n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
			end
			if (!(start && busy)) begin
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (cmd_q.size() != 0) begin
					cur_cmd = cmd_q.pop_front();
					op <= cur_cmd.op;
					is_write <= cur_cmd.is_write;
					drive <= cur_cmd.drive;
					block <= cur_cmd.block;
					block_count <= cur_cmd.block_count;
					st0 <= cur_cmd.st0;
					st1 <= cur_cmd.st1;
					st2 <= cur_cmd.st2;
					res_cylinder <= cur_cmd.res_cylinder;
					res_head <= cur_cmd.res_head;
					res_sector <= cur_cmd.res_sector;
					start <= 1'b1;
					idle_left = pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				flag_mismatch("result with nothing expected, status", status, -1);
			end else begin
				mon_want = due_results.pop_front();
				if (status !== mon_want.status) flag_mismatch("status", status, mon_want.status);
				if (out_drive !== mon_want.drive) flag_mismatch("out_drive", out_drive, mon_want.drive);
				if (cylinder !== mon_want.cylinder)
					flag_mismatch("cylinder", cylinder, mon_want.cylinder);
				if (head !== mon_want.head) flag_mismatch("head", head, mon_want.head);
				if (sector !== mon_want.sector) flag_mismatch("sector", sector, mon_want.sector);
				if (count !== mon_want.count) flag_mismatch("count", count, mon_want.count);
				if (write_dir !== mon_want.write_dir)
					flag_mismatch("write_dir", write_dir, mon_want.write_dir);
				checked_n++;
				stat_seen[mon_want.status]++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("floppy_chs_transfer_sequencer_core verification failed");
			$finish;
		end
	end

	task automatic queue_cmd(input cmd_t c);
		cmd_q.push_back(c);
		pushed_n++;
		if (c.op != OP_UNUSED) items_n++;
	endtask

	task automatic wait_taken();
		while (accepted_n != pushed_n) @(negedge clk);
	endtask

	task automatic settle();
		wait_taken();
		while (due_results.size() != 0 || busy) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic cmd_t blank_cmd(input logic [1:0] o);
		cmd_t c;
		c = '0;
		c.op = o;
		return c;
	endfunction

	function automatic cmd_t request_cmd(input logic w, input logic d,
		input int unsigned blk, input int unsigned cnt);
		cmd_t c;
		c = blank_cmd(fcts_pkg::OP_REQUEST);
		c.is_write = w;
		c.drive = d;
		c.block = blk[14:0];
		c.block_count = cnt[14:0];
		return c;
	endfunction

	function automatic cmd_t noise_cmd();
		cmd_t c;
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		c = raw[$bits(cmd_t)-1:0];
		return c;
	endfunction

	// controller report whose ending CHS lands exactly count sectors past the chunk start
	function automatic cmd_t clean_report();
		cmd_t c;
		int unsigned spt, spc, lin, rem, tmp;
		c = blank_cmd(fcts_pkg::OP_RESULT);
		spt = eff_spt();
		spc = 2 * spt;
		if ($urandom_range(0, 3) == 0 && c_sec + c_cnt <= 255) begin
			c.res_cylinder = c_cyl;
			c.res_head = {7'd0, c_head};
			lin = c_sec + c_cnt;
			c.res_sector = lin[7:0];
		end else begin
			lin = c_cyl * spc + c_head * spt + c_sec + c_cnt;
			tmp = lin / spc;
			c.res_cylinder = tmp[7:0];
			rem = lin % spc;
			tmp = rem / spt;
			c.res_head = tmp[7:0];
			tmp = rem % spt;
			c.res_sector = tmp[7:0];
		end
		return c;
	endfunction

	task automatic finish_chunk();
		cmd_t c;
		int roll;
		logic [7:0] flip;
		c = clean_report();
		roll = $urandom_range(0, 99);
		flip = 8'($urandom_range(1, 255));
		if (roll < 70) begin
			c.st0 = 8'($urandom_range(0, 7));
		end else if (roll < 76) begin
			c.st0 = 8'($urandom_range(0, 255));
			c.st0 = c.st0 | (8'h08 << $urandom_range(0, 4));
		end else if (roll < 82) begin
			c.st1 = 8'($urandom_range(1, 255));
		end else if (roll < 86) begin
			c.st1 = 8'h02;
		end else if (roll < 90) begin
			c.st2 = 8'($urandom_range(1, 255));
		end else begin
			case ($urandom_range(0, 2))
				0: c.res_cylinder = c.res_cylinder ^ flip;
				1: c.res_head = c.res_head ^ flip;
				default: c.res_sector = c.res_sector ^ flip;
			endcase
		end
		queue_cmd(c);
	endtask

	task automatic run_transfer();
		int unsigned maxb, blk, room, cnt, rounds, roll;
		cmd_t c;
		if (cfg_fsb == 0 || cfg_total < cfg_fsb) begin
			queue_cmd(request_cmd(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				$urandom_range(0, 40), $urandom_range(0, 40)));
			return;
		end
		maxb = cfg_total / cfg_fsb;
		if ($urandom_range(0, 3) == 0)
			blk = maxb - 1 - $urandom_range(0, (maxb - 1 < 20) ? maxb - 1 : 20);
		else
			blk = $urandom_range(0, maxb - 1);
		room = maxb - blk;
		if ($urandom_range(0, 9) < 7)
			cnt = $urandom_range(1, (room < 6) ? room : 6);
		else
			cnt = $urandom_range(1, room);
		queue_cmd(request_cmd(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), blk, cnt));
		rounds = $urandom_range(2, 24);
		for (int k = 0; k < rounds; k++) begin
			wait_taken();
			if (!req_open) break;
			roll = $urandom_range(0, 99);
			if (roll < 82) begin
				queue_cmd(blank_cmd(fcts_pkg::OP_FETCH));
				if (roll < 8) queue_cmd(blank_cmd(fcts_pkg::OP_FETCH));
				wait_taken();
				if (chunk_out) finish_chunk();
			end else if (roll < 91) begin
				c = noise_cmd();
				c.op = fcts_pkg::OP_RESULT;
				queue_cmd(c);
			end else begin
				queue_cmd(noise_cmd());
			end
		end
		if ($urandom_range(0, 4) == 0) queue_cmd(blank_cmd(fcts_pkg::OP_FETCH));
	endtask

	// register write with random junk above the register's width
	task automatic write_reg(input logic [1:0] idx, input int unsigned val, input int width);
		logic [14:0] d;
		int unsigned km;
		km = (1 << width) - 1;
		d = 15'($urandom_range(0, 32767));
		d = (d & ~km[14:0]) | (val[14:0] & km[14:0]);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		case (idx)
			fcts_pkg::CFG_SECTORS_PER_TRACK: cfg_spt = d[5:0];
			fcts_pkg::CFG_FS_BLOCK_SECTORS: cfg_fsb = d[3:0];
			fcts_pkg::CFG_TOTAL_SECTORS: cfg_total = d;
			default: ;
		endcase
	endtask

	int share[8] = '{150, 180, 150, 100, 40, 170, 170, 165};

	initial begin
		cmd_t c;
		int goal;
		int unsigned s, f, t;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset geometry: 18 sectors, 2 per block, 2880 total
		queue_cmd(blank_cmd(fcts_pkg::OP_FETCH));
		c = '1;
		c.op = fcts_pkg::OP_RESULT;
		queue_cmd(c);
		c = '1;
		queue_cmd(c);
		queue_cmd(request_cmd(1'b0, 1'b0, 0, 0));
		queue_cmd(request_cmd(1'b0, 1'b1, 1440, 1));
		queue_cmd(request_cmd(1'b1, 1'b0, 0, 1441));
		queue_cmd(request_cmd(1'b0, 1'b0, 1439, 2));
		queue_cmd(request_cmd(1'b1, 1'b1, 32767, 32767));
		queue_cmd(request_cmd(1'b1, 1'b1, 1439, 1));
		queue_cmd(blank_cmd(fcts_pkg::OP_FETCH));
		queue_cmd(blank_cmd(fcts_pkg::OP_FETCH));
		wait_taken();
		c = clean_report();
		c.st1 = 8'h02;
		queue_cmd(c);
		queue_cmd(blank_cmd(fcts_pkg::OP_FETCH));
		wait_taken();
		c = clean_report();
		c.st0 = 8'hf8;
		queue_cmd(c);
		queue_cmd(blank_cmd(fcts_pkg::OP_FETCH));
		wait_taken();
		c = clean_report();
		c.st0 = 8'h07;
		queue_cmd(c);
		queue_cmd(blank_cmd(fcts_pkg::OP_FETCH));
		queue_cmd(request_cmd(1'b0, 1'b0, 0, 20));
		queue_cmd(blank_cmd(fcts_pkg::OP_FETCH));
		wait_taken();
		c = clean_report();
		c.res_sector = c.res_sector + 8'd1;
		queue_cmd(c);
		queue_cmd(blank_cmd(fcts_pkg::OP_FETCH));
		wait_taken();
		queue_cmd(clean_report());
		queue_cmd(blank_cmd(fcts_pkg::OP_FETCH));
		wait_taken();
		queue_cmd(clean_report());
		queue_cmd(request_cmd(1'b0, 1'b1, 0, 1440));
		queue_cmd(blank_cmd(fcts_pkg::OP_FETCH));
		wait_taken();
		c = clean_report();
		c.st1 = 8'h02;
		queue_cmd(c);

		for (int p = 0; p < 8; p++) begin
			settle();
			case (p)
				0: begin s = 63; f = 8; t = 32130; end
				1: begin s = 1; f = 1; t = 32130; end
				2: begin s = 0; f = 15; t = 32767; end
				3: begin s = 9; f = 1; t = 1; end
				4: begin s = 18; f = 0; t = 2880; end
				7: begin s = 5; f = 4; t = 32130; end
				default: begin
					s = $urandom_range(1, 63);
					f = $urandom_range(1, 8);
					t = $urandom_range(1, 32130);
				end
			endcase
			write_reg(fcts_pkg::CFG_SECTORS_PER_TRACK, s, 6);
			write_reg(fcts_pkg::CFG_FS_BLOCK_SECTORS, f, 4);
			write_reg(fcts_pkg::CFG_TOTAL_SECTORS, t, 15);
			@(posedge clk);
			cfg_we <= 1'b0;
			@(negedge clk);
			goal = items_n + share[p];
			while (items_n < goal) begin
				if ($urandom_range(0, 99) < 12) queue_cmd(noise_cmd());
				else run_transfer();
			end
		end

		wait_taken();
		for (int k = 0; k < 5000 && due_results.size() != 0; k++) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (due_results.size() != 0)
			flag_mismatch("results never seen, count", 0, due_results.size());

		$display("covered %0d commands, %0d results checked, reset geometry plus 8 settings",
			items_n, checked_n);
		$display("status mix: accepted %0d bad %0d issued %0d none %0d ok %0d wprot %0d fail %0d",
			stat_seen[fcts_pkg::STAT_ACCEPTED], stat_seen[fcts_pkg::STAT_BAD_REQ],
			stat_seen[fcts_pkg::STAT_ISSUED], stat_seen[fcts_pkg::STAT_NO_CHUNK],
			stat_seen[fcts_pkg::STAT_XFER_OK], stat_seen[fcts_pkg::STAT_WRITE_PROT],
			stat_seen[fcts_pkg::STAT_XFER_FAIL]);
		if (errors == 0) begin
			$display("floppy_chs_transfer_sequencer_core verification clean");
		end else begin
			$display("floppy_chs_transfer_sequencer_core verification failed");
		end
		$finish;
	end

endmodule

>>> floppy_chs_transfer_sequencer_core.f
hdl/fcts_pkg.sv
hdl/fcts_divu.sv
hdl/floppy_chs_transfer_sequencer_core.sv
hdl/fcts_checker.sv
tb/floppy_chs_transfer_sequencer_core_tb.sv
